/* rtl/core/vertex_transform_perspective_divide_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the vertex transform and perspective divide block
// ---------------------------------------------------------------------------
`ifndef VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_DEFINES_SVH
`define VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_DEFINES_SVH
`ifndef ASSERT_OFF
// Property checked at each rising edge, off while the reset is high
`define VTPD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("vtpd assertion failed");
// Property checked at every rising edge, reset included
`define VTPD_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("vtpd assertion failed");
`else
`define VTPD_ASSERT(label, clk, rst, prop)
`define VTPD_ASSERT_NR(label, clk, prop)
`endif
`endif

/* rtl/core/vtpd_pkg.sv */
// ---------------------------------------------------------------------------
// vtpd_pkg
// Shared widths, codes and types of the vertex transform and divide pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package vtpd_pkg;
   localparam int COORD_W  = 32;
   localparam int FRAC_W   = 16;
   localparam int COEF_W   = 32;
   localparam int NUM_REGS = 8;
   localparam int REG_W    = 2 * COEF_W;
   localparam int IDX_W    = $clog2(NUM_REGS);
   localparam int PROD_W   = COORD_W + COEF_W;
   localparam int PAIR_W   = PROD_W + 1;
   localparam int ACC_W    = PROD_W + 2;
   localparam int SH_W     = ACC_W - FRAC_W;
   localparam int NUM_W    = COORD_W + FRAC_W;
   localparam int REM_W    = COORD_W + 1;
   // |w| * 10000 > 2^FRAC_W holds exactly when |w| exceeds this floor
   localparam int THRESH_MAG = (1 << FRAC_W) / 10000;

   typedef enum logic [1:0] {
      ACT_XFORM = 2'd0,
      ACT_DIV   = 2'd1,
      ACT_BOTH  = 2'd2,
      ACT_PASS  = 2'd3
   } action_type;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [3:0][COORD_W-1:0] vec_type;
   typedef logic [3:0][3:0][COEF_W-1:0] coef_mat_type;

   typedef struct packed {
      action_type        act;
      logic              do_div;
      logic              sat;
      logic [2:0]        neg;
      logic [COORD_W-1:0] md;
      vec_type           v;
   } side_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [NUM_W-1:0] nq;
   } lane_type;

   typedef lane_type [2:0] lanes_type;

   function automatic logic [COORD_W-1:0] magnitude(coord_type v);
      return v[COORD_W-1] ? (~v + COORD_W'(1)) : v;
   endfunction
endpackage
`default_nettype wire

/* rtl/core/vtpd_xform.sv */
// ---------------------------------------------------------------------------
// vtpd_xform
// Four-stage 4x4 matrix multiply with round to nearest and saturation.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module vtpd_xform
   import vtpd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         en,
   input  wire logic         in_valid,
   input  wire action_type   in_act,
   input  wire vec_type      in_v,
   input  wire coef_mat_type coef,
   output logic              out_valid,
   output action_type        out_act,
   output vec_type           out_v,
   output logic              out_sat
);
   localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (FRAC_W - 1);
   localparam logic signed [SH_W-1:0] SAT_MAX =
      {{(SH_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
   localparam logic signed [SH_W-1:0] SAT_MIN =
      {{(SH_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

   logic [3:0]        vld_ff;
   action_type        act_ff [4];
   vec_type           v_ff [3];
   logic signed [PROD_W-1:0] prod_ff [4][4];
   logic signed [PAIR_W-1:0] pair_ff [4][2];
   logic signed [ACC_W-1:0]  acc_ff [4];
   vec_type           res_ff;
   logic              sat_ff;
   vec_type           res_in;
   logic              sat_in;
   logic signed [SH_W-1:0] sh;

   always_comb begin
      res_in = v_ff[2];
      sat_in = 1'b0;
      sh     = '0;
      if (act_ff[2] inside {ACT_XFORM, ACT_BOTH}) begin
         for (int r = 0; r < 4; r++) begin
            sh = acc_ff[r][ACC_W-1:FRAC_W];
            if (sh > SAT_MAX) begin
               res_in[r] = SAT_MAX[COORD_W-1:0];
               sat_in    = 1'b1;
            end else if (sh < SAT_MIN) begin
               res_in[r] = SAT_MIN[COORD_W-1:0];
               sat_in    = 1'b1;
            end else begin
               res_in[r] = sh[COORD_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         act_ff[0] <= in_act;
         v_ff[0]   <= in_v;
         for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
               prod_ff[r][c] <= $signed(coef[r][c]) * $signed(in_v[c]);
            end
         end
         act_ff[1] <= act_ff[0];
         v_ff[1]   <= v_ff[0];
         for (int r = 0; r < 4; r++) begin
            pair_ff[r][0] <= PAIR_W'(prod_ff[r][0]) + PAIR_W'(prod_ff[r][1]);
            pair_ff[r][1] <= PAIR_W'(prod_ff[r][2]) + PAIR_W'(prod_ff[r][3]);
         end
         act_ff[2] <= act_ff[1];
         v_ff[2]   <= v_ff[1];
         for (int r = 0; r < 4; r++) begin
            acc_ff[r] <= ACC_W'(pair_ff[r][0]) + ACC_W'(pair_ff[r][1]) + RND;
         end
         act_ff[3] <= act_ff[2];
         res_ff    <= res_in;
         sat_ff    <= sat_in;
      end
   end

   assign out_valid = vld_ff[3];
   assign out_act   = act_ff[3];
   assign out_v     = res_ff;
   assign out_sat   = sat_ff;
endmodule
`default_nettype wire

/* rtl/core/vtpd_div_stage.sv */
// ---------------------------------------------------------------------------
// vtpd_div_stage
// One restoring-division step for the three coordinate lanes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module vtpd_div_stage
   import vtpd_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      en,
   input  wire logic      in_valid,
   input  wire side_type  in_side,
   input  wire lanes_type in_lanes,
   output logic           out_valid,
   output side_type       out_side,
   output lanes_type      out_lanes
);
   logic      vld_ff;
   side_type  side_ff;
   lanes_type lanes_ff;
   lanes_type lanes_in;
   logic [REM_W-1:0] cand;
   logic             ge;

   always_comb begin
      cand = '0;
      ge   = 1'b0;
      for (int i = 0; i < 3; i++) begin
         // shift the next numerator bit in, subtract when it fits
         cand = {in_lanes[i].rem[REM_W-2:0], in_lanes[i].nq[NUM_W-1]};
         ge   = cand >= {1'b0, in_side.md};
         lanes_in[i].rem = ge ? (cand - {1'b0, in_side.md}) : cand;
         lanes_in[i].nq  = {in_lanes[i].nq[NUM_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff  <= in_side;
         lanes_ff <= lanes_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_side  = side_ff;
   assign out_lanes = lanes_ff;
endmodule
`default_nettype wire

/* rtl/core/vtpd_div.sv */
// ---------------------------------------------------------------------------
// vtpd_div
// Perspective divide: setup, one quotient bit per stage, round and clamp.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module vtpd_div
   import vtpd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       en,
   input  wire logic       in_valid,
   input  wire action_type in_act,
   input  wire vec_type    in_v,
   input  wire logic       in_sat,
   output logic            out_valid,
   output action_type      out_act,
   output vec_type         out_v,
   output logic            out_div,
   output logic            out_sat
);
   localparam logic [NUM_W:0] LIM_POS = (NUM_W+1)'({(COORD_W-1){1'b1}});
   localparam logic [NUM_W:0] LIM_NEG = LIM_POS + (NUM_W+1)'(1);

   logic      vld_w [NUM_W+1];
   side_type  side_w [NUM_W+1];
   lanes_type lanes_w [NUM_W+1];

   side_type  side0_in;
   lanes_type lanes0_in;
   logic      vld0_ff;
   side_type  side0_ff;
   lanes_type lanes0_ff;

   logic      vldp_ff;
   side_type  sidep_ff;
   logic [NUM_W:0] q_ff [3];
   logic [NUM_W:0] q_in [3];

   logic       vldo_ff;
   action_type acto_ff;
   vec_type    vo_ff;
   logic       divo_ff;
   logic       sato_ff;
   vec_type    vo_in;
   logic       sato_in;
   logic [NUM_W:0]   lim;
   logic [COORD_W-1:0] qm;
   logic [COORD_W-1:0] mw;

   always_comb begin
      mw = magnitude(in_v[3]);
      side0_in.act    = in_act;
      side0_in.do_div = (in_act inside {ACT_DIV, ACT_BOTH}) &&
                        (mw > COORD_W'(THRESH_MAG));
      side0_in.sat    = in_sat;
      side0_in.md     = mw;
      side0_in.v      = in_v;
      for (int i = 0; i < 3; i++) begin
         side0_in.neg[i]   = in_v[i][COORD_W-1] ^ in_v[3][COORD_W-1];
         lanes0_in[i].rem  = '0;
         lanes0_in[i].nq   = {magnitude(in_v[i]), {FRAC_W{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
      end else if (en) begin
         vld0_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side0_ff  <= side0_in;
         lanes0_ff <= lanes0_in;
      end
   end

   assign vld_w[0]   = vld0_ff;
   assign side_w[0]  = side0_ff;
   assign lanes_w[0] = lanes0_ff;

   for (genvar k = 0; k < NUM_W; k++) begin : g_step
      vtpd_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (vld_w[k]),
         .in_side   (side_w[k]),
         .in_lanes  (lanes_w[k]),
         .out_valid (vld_w[k+1]),
         .out_side  (side_w[k+1]),
         .out_lanes (lanes_w[k+1])
      );
   end

   // round to nearest, ties away from zero: bump when 2*rem >= divisor
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         q_in[i] = {1'b0, lanes_w[NUM_W][i].nq} +
                   (NUM_W+1)'({lanes_w[NUM_W][i].rem, 1'b0} >=
                              {2'b00, side_w[NUM_W].md});
      end
   end

   always_comb begin
      vo_in   = sidep_ff.v;
      sato_in = sidep_ff.sat;
      lim     = '0;
      qm      = '0;
      if (sidep_ff.do_div) begin
         for (int i = 0; i < 3; i++) begin
            lim = sidep_ff.neg[i] ? LIM_NEG : LIM_POS;
            if (q_ff[i] > lim) begin
               qm      = lim[COORD_W-1:0];
               sato_in = 1'b1;
            end else begin
               qm = q_ff[i][COORD_W-1:0];
            end
            vo_in[i] = sidep_ff.neg[i] ? (~qm + COORD_W'(1)) : qm;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vldp_ff <= 1'b0;
         vldo_ff <= 1'b0;
      end else if (en) begin
         vldp_ff <= vld_w[NUM_W];
         vldo_ff <= vldp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sidep_ff <= side_w[NUM_W];
         q_ff     <= q_in;
         acto_ff  <= sidep_ff.act;
         vo_ff    <= vo_in;
         divo_ff  <= sidep_ff.do_div;
         sato_ff  <= sato_in;
      end
   end

   assign out_valid = vldo_ff;
   assign out_act   = acto_ff;
   assign out_v     = vo_ff;
   assign out_div   = divo_ff;
   assign out_sat   = sato_ff;
endmodule
`default_nettype wire

/* rtl/core/vertex_transform_perspective_divide.sv */
// Pipeline from request accept to result valid: 4 transform stages, 1 divide
// setup stage, 48 quotient-bit stages, 1 rounding stage, 1 output.
// Throughput: one vertex per cycle; every stage advances together whenever
// the output register is empty or being taken.
// Reset: synchronous; clears all valid bits and loads the identity matrix.
`timescale 1ns / 1ps
`default_nettype none
`include "vertex_transform_perspective_divide_defines.svh"
// ---------------------------------------------------------------------------
// vertex_transform_perspective_divide
// Homogeneous vertex transform by a 4x4 matrix and perspective divide.
// ---------------------------------------------------------------------------
module vertex_transform_perspective_divide
   import vtpd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wen,
   input  wire logic [IDX_W-1:0]     csr_index,
   input  wire logic [REG_W-1:0]     csr_wdata,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [4*COORD_W-1:0] req_tdata,  // in_x, in_y, in_z, in_w
   input  wire logic [1:0]           req_tuser,  // action
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [4*COORD_W-1:0]      rsp_tdata,  // out_x, out_y, out_z, out_w
   output logic [1:0]                rsp_tuser   // divided, saturated
);
   localparam logic [REG_W-1:0] ONE_LO = REG_W'(1) << FRAC_W;
   localparam logic [REG_W-1:0] ONE_HI = REG_W'(1) << (FRAC_W + COEF_W);

   logic [REG_W-1:0] matrix_ff [NUM_REGS];
   coef_mat_type     coef;
   logic             en;

   logic       x_valid;
   action_type x_act;
   vec_type    x_v;
   logic       x_sat;
   action_type o_act;
   vec_type    o_v;
   logic       o_div;
   logic       o_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            matrix_ff[i] <= '0;
         end
         matrix_ff[0] <= ONE_LO;
         matrix_ff[2] <= ONE_HI;
         matrix_ff[5] <= ONE_LO;
         matrix_ff[7] <= ONE_HI;
      end else if (csr_wen) begin
         matrix_ff[csr_index] <= csr_wdata;
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            coef[r][c] = matrix_ff[r*2 + c/2][(c%2)*COEF_W +: COEF_W];
         end
      end
   end

   // advance the whole pipe unless a finished result is held
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   vtpd_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_act    (action_type'(req_tuser)),
      .in_v      (vec_type'(req_tdata)),
      .coef      (coef),
      .out_valid (x_valid),
      .out_act   (x_act),
      .out_v     (x_v),
      .out_sat   (x_sat)
   );

   vtpd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (x_valid),
      .in_act    (x_act),
      .in_v      (x_v),
      .in_sat    (x_sat),
      .out_valid (rsp_tvalid),
      .out_act   (o_act),
      .out_v     (o_v),
      .out_div   (o_div),
      .out_sat   (o_sat)
   );

   assign rsp_tdata = o_v;
   assign rsp_tuser = {o_sat, o_div};

   `VTPD_ASSERT_NR(a_reset_empty, clock, reset |=> !rsp_tvalid)
   `VTPD_ASSERT(a_pass_flags, clock, reset, (rsp_tvalid && o_act == ACT_PASS) |-> (rsp_tuser == 2'b00))
   `VTPD_ASSERT(a_xform_nodiv, clock, reset, (rsp_tvalid && o_act == ACT_XFORM) |-> !o_div)
   `VTPD_ASSERT(a_div_thresh, clock, reset, (rsp_tvalid && o_div) |-> (magnitude(o_v[3]) > COORD_W'(THRESH_MAG)))
endmodule
`default_nettype wire
